// ===== hw/rtl/plm_pkg.sv =====
// Package for the pixel layer mixer: line and pen constants, the sprite
// key codes and the result entry type shared by the top level and its queue.
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

  // Line and pen geometry.
  localparam int LINE_WIDTH = 256;
  localparam int PEN_ORIGIN = 32;

  localparam int COL_W = 8;
  localparam int PEN_W = 15;
  localparam int NIB_W = 4;
  localparam int TBL_IDX_W = 5;
  localparam int TBL_DATA_W = 8;
  localparam int TBL_DEPTH = 32;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_WIDTH - 1);
  localparam logic [COL_W-1:0] SPRITE_MIN_COL = COL_W'(4);
  localparam logic [NIB_W-1:0] NIB_CLEAR = NIB_W'(4'hf);
  localparam logic [PEN_W-1:0] PEN_OFFSET = PEN_W'(PEN_ORIGIN);

  // Request kinds on the input channel.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_TABLE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_COLOR_BANK = 1'b0;

  // Result queue geometry.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef struct packed {
    logic [PEN_W-1:0] pen;
    logic [COL_W-1:0] column;
    logic             last;
  } plm_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plm_outq.sv =====
// Result queue for the pixel layer mixer: four entries, up to two writes and
// one read per cycle. Depends on plm_pkg for the entry type and its depth.
`timescale 1ns / 1ps
`default_nettype none

module plm_outq (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [1:0]                     wr_cnt,
  input  plm_pkg::plm_result_t           wr_data0,
  input  plm_pkg::plm_result_t           wr_data1,
  input  wire                            rd_en,
  output plm_pkg::plm_result_t           rd_data,
  output logic                           not_empty,
  output logic                           room_for_two
);

  plm_pkg::plm_result_t            mem_r [plm_pkg::OQ_DEPTH];
  logic [plm_pkg::OQ_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [plm_pkg::OQ_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [plm_pkg::OQ_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [plm_pkg::OQ_PTR_W-1:0]    wr_ptr_inc;

  assign wr_ptr_inc   = wr_ptr_r + plm_pkg::OQ_PTR_W'(1);
  assign rd_data      = mem_r[rd_ptr_r];
  assign not_empty    = (cnt_r != '0);
  assign room_for_two = (cnt_r <= plm_pkg::OQ_CNT_W'(plm_pkg::OQ_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + plm_pkg::OQ_PTR_W'(wr_cnt);
    rd_ptr_nxt = rd_ptr_r + plm_pkg::OQ_PTR_W'(rd_en);
    cnt_nxt    = cnt_r + plm_pkg::OQ_CNT_W'(wr_cnt) - plm_pkg::OQ_CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= wr_data0;
    end
    if (wr_cnt == 2'd2) begin
      mem_r[wr_ptr_inc] <= wr_data1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_layer_mixer_with_drop_shadow.sv =====
// Top level of the pixel layer mixer with a one-pixel drop shadow.
// Depends on plm_pkg and on the result queue plm_outq.
`timescale 1ns / 1ps
`default_nettype none

// The mixer takes one request per clock while the mixing stage does not wait:
// either a pixel of the current scanline or a write into the 32-entry sprite
// color table. A pixel request is captured in an input register and mixed from
// there (text over sprite over background, with a two-tap sprite delay that
// fills one-pixel gaps), and its results go into a four-entry result queue
// that drives the output channel. Because the first front pixel after
// background darkens the pixel before it, every pixel is held back by one
// request: a pixel is emitted when the next pixel request arrives, and at the
// last column of the line both the held pixel and the new one come out, the
// second marked with last. A result reaches the output by way of the result
// queue. The block sustains one request per cycle as long as the consumer
// takes one result per cycle; the mixing stage waits only when the result
// queue cannot take two more entries, which happens when results pile up
// behind a stalled consumer. The sprite color table has no reset and must be
// loaded before sprites are shown; the color bank register (byte address 0,
// reset 0) selects the upper half of text and sprite colors and should only
// be written while no pixel is in flight.
module pixel_layer_mixer_with_drop_shadow (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Pixel and table-write requests.
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_action,
  input  wire  [plm_pkg::COL_W-1:0]           in_column,
  input  wire                                 in_text_on,
  input  wire  [plm_pkg::NIB_W-1:0]           in_text_color,
  input  wire  [plm_pkg::NIB_W-1:0]           in_sprite_nibble,
  input  wire  [7:0]                          in_bg_index,
  input  wire  [5:0]                          in_shade,
  input  wire  [plm_pkg::TBL_IDX_W-1:0]       in_table_index,
  input  wire  [plm_pkg::TBL_DATA_W-1:0]      in_table_data,
  // Emitted pixels.
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [plm_pkg::PEN_W-1:0]           out_pen,
  output logic [plm_pkg::COL_W-1:0]           out_pixel_column,
  output logic                                out_last,
  // Configuration port.
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [2:0]                          paddr,
  input  wire  [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  // Configuration register.
  logic color_bank_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == plm_pkg::REG_COLOR_BANK) ? {31'b0, color_bank_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_bank_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == plm_pkg::REG_COLOR_BANK)) begin
      color_bank_r <= pwdata[0];
    end
  end

  // Input register stage.
  logic                                s1_valid_r;
  logic                                s1_action_r;
  logic [plm_pkg::COL_W-1:0]           s1_column_r;
  logic                                s1_text_on_r;
  logic [plm_pkg::NIB_W-1:0]           s1_text_color_r;
  logic [plm_pkg::NIB_W-1:0]           s1_nibble_r;
  logic [7:0]                          s1_bg_r;
  logic [5:0]                          s1_shade_r;
  logic [plm_pkg::TBL_IDX_W-1:0]       s1_tidx_r;
  logic [plm_pkg::TBL_DATA_W-1:0]      s1_tdata_r;

  logic advance;
  logic room_for_two;

  // The held request moves on when the queue can take both possible results.
  assign advance  = s1_valid_r && room_for_two;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action_r     <= in_action;
      s1_column_r     <= in_column;
      s1_text_on_r    <= in_text_on;
      s1_text_color_r <= in_text_color;
      s1_nibble_r     <= in_sprite_nibble;
      s1_bg_r         <= in_bg_index;
      s1_shade_r      <= in_shade;
      s1_tidx_r       <= in_table_index;
      s1_tdata_r      <= in_table_data;
    end
  end

  // Sprite color table. Entries are undefined until loaded.
  logic [plm_pkg::TBL_DATA_W-1:0] color_tbl_r [plm_pkg::TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (advance && (s1_action_r == plm_pkg::ACT_TABLE)) begin
      color_tbl_r[s1_tidx_r] <= s1_tdata_r;
    end
  end

  // Line state: sprite delay taps, the front-pixel flag and the held pixel.
  logic [plm_pkg::NIB_W-1:0] tap_one_r, tap_one_nxt;
  logic [plm_pkg::NIB_W-1:0] tap_two_r, tap_two_nxt;
  logic                      prev_front_r, prev_front_nxt;
  logic [plm_pkg::PEN_W-1:0] held_pen_r, held_pen_nxt;
  logic [plm_pkg::COL_W-1:0] held_col_r, held_col_nxt;
  logic                      held_valid_r, held_valid_nxt;

  // Mixing logic.
  logic                      pixel_go;
  logic                      line_start;
  logic [plm_pkg::NIB_W-1:0] d1, d2, sp;
  logic                      prev_front;
  logic                      sprite_hit;
  logic                      front;
  logic [7:0]                pal_byte;
  logic [plm_pkg::PEN_W-1:0] pen;
  logic                      shadow;
  logic                      flush;
  logic [1:0]                wr_cnt;
  plm_pkg::plm_result_t      held_res, new_res, wr_data0, wr_data1;

  always_comb begin
    pixel_go   = advance && (s1_action_r == plm_pkg::ACT_PIXEL);
    line_start = (s1_column_r == '0);

    // A new line starts with the taps cleared to zero and counts as after a front pixel.
    d1         = line_start ? '0 : tap_one_r;
    d2         = line_start ? '0 : tap_two_r;
    prev_front = line_start ? 1'b1 : prev_front_r;

    // Gap fill: a single transparent pixel between two sprite pixels
    // shows the sprite value from two pixels back.
    if ((s1_nibble_r != plm_pkg::NIB_CLEAR) && (d1 == plm_pkg::NIB_CLEAR)
        && (d2 != plm_pkg::NIB_CLEAR)) begin
      sp = d2;
    end else begin
      sp = d1;
    end
    sprite_hit = (sp != plm_pkg::NIB_CLEAR) && (s1_column_r >= plm_pkg::SPRITE_MIN_COL);
    pal_byte   = sprite_hit ? color_tbl_r[{color_bank_r, sp}] : s1_bg_r;

    if (s1_text_on_r) begin
      pen   = {{(plm_pkg::PEN_W - plm_pkg::NIB_W - 1){1'b0}}, color_bank_r, s1_text_color_r};
      front = 1'b1;
    end else begin
      // The shade fills the low six bits under the palette byte.
      pen   = {1'b0, pal_byte, s1_shade_r} + plm_pkg::PEN_OFFSET;
      front = sprite_hit;
    end

    shadow = front && !prev_front && !line_start;
    flush  = (s1_column_r >= plm_pkg::LAST_COL);

    held_res.pen    = shadow ? '0 : held_pen_r;
    held_res.column = held_col_r;
    held_res.last   = !flush;
    new_res.pen     = pen;
    new_res.column  = s1_column_r;
    new_res.last    = 1'b1;

    // Pack the results into the queue's write slots in order.
    wr_data0 = held_valid_r ? held_res : new_res;
    wr_data1 = new_res;
    if (pixel_go) begin
      wr_cnt = 2'(held_valid_r) + 2'(flush);
    end else begin
      wr_cnt = 2'd0;
    end

    tap_one_nxt    = tap_one_r;
    tap_two_nxt    = tap_two_r;
    prev_front_nxt = prev_front_r;
    held_pen_nxt   = held_pen_r;
    held_col_nxt   = held_col_r;
    held_valid_nxt = held_valid_r;
    if (pixel_go) begin
      tap_one_nxt    = s1_nibble_r;
      tap_two_nxt    = d1;
      prev_front_nxt = front;
      if (flush) begin
        held_pen_nxt   = '0;
        held_col_nxt   = '0;
        held_valid_nxt = 1'b0;
      end else begin
        held_pen_nxt   = pen;
        held_col_nxt   = s1_column_r;
        held_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_one_r    <= '0;
      tap_two_r    <= '0;
      prev_front_r <= 1'b1;
      held_pen_r   <= '0;
      held_col_r   <= '0;
      held_valid_r <= 1'b0;
    end else begin
      tap_one_r    <= tap_one_nxt;
      tap_two_r    <= tap_two_nxt;
      prev_front_r <= prev_front_nxt;
      held_pen_r   <= held_pen_nxt;
      held_col_r   <= held_col_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  // Result queue feeding the output channel.
  plm_pkg::plm_result_t head;
  logic                 not_empty;

  plm_outq u_outq (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_cnt       (wr_cnt),
    .wr_data0     (wr_data0),
    .wr_data1     (wr_data1),
    .rd_en        (not_empty && out_ready),
    .rd_data      (head),
    .not_empty    (not_empty),
    .room_for_two (room_for_two)
  );

  assign out_valid        = not_empty;
  assign out_pen          = head.pen;
  assign out_pixel_column = head.column;
  assign out_last         = head.last;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for pixel_layer_mixer_with_drop_shadow. It sends pixel and color table
// requests with random gaps, predicts every emitted pixel and checks each one in order.
// Depends on plm_pkg and the mixer RTL.

module testbench;
  import plm_pkg::*;

  // The run is a few thousand requests. Even at the slowest legal pace it stays far below
  // this limit.
  localparam int CYCLE_LIMIT = 600000;
  // A pixel reaches the output by way of the input register and the result queue. A table write
  // never produces a result. Waiting this long after the last expected pixel leaves the block
  // idle before a register write.
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS = 40;
  localparam int MAX_GAP = 13;
  localparam logic [2:0] BANK_ADDR = 3'(4 * int'(REG_COLOR_BANK));

  // One request as the sender sees it. Pixel fields ride along on table writes and the reverse.
  typedef struct {
    logic                  action;
    logic [COL_W-1:0]      column;
    logic                  text_on;
    logic [NIB_W-1:0]      text_color;
    logic [NIB_W-1:0]      nibble;
    logic [7:0]            bg;
    logic [5:0]            shade;
    logic [TBL_IDX_W-1:0]  tidx;
    logic [TBL_DATA_W-1:0] tdata;
  } mix_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_action = ACT_PIXEL;
  logic [COL_W-1:0]      in_column = '0;
  logic                  in_text_on = 1'b0;
  logic [NIB_W-1:0]      in_text_color = '0;
  logic [NIB_W-1:0]      in_sprite_nibble = '0;
  logic [7:0]            in_bg_index = '0;
  logic [5:0]            in_shade = '0;
  logic [TBL_IDX_W-1:0]  in_table_index = '0;
  logic [TBL_DATA_W-1:0] in_table_data = '0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PEN_W-1:0] out_pen;
  logic [COL_W-1:0] out_pixel_column;
  logic             out_last;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_layer_mixer_with_drop_shadow dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_column        (in_column),
    .in_text_on       (in_text_on),
    .in_text_color    (in_text_color),
    .in_sprite_nibble (in_sprite_nibble),
    .in_bg_index      (in_bg_index),
    .in_shade         (in_shade),
    .in_table_index   (in_table_index),
    .in_table_data    (in_table_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pen          (out_pen),
    .out_pixel_column (out_pixel_column),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The bench keeps its own copy of the mixer state: the sprite taps, the front flag, the
  // pixel held back for the shadow decision, the color table and the color bank.
  logic [NIB_W-1:0]      tap_one;
  logic [NIB_W-1:0]      tap_two;
  logic                  last_front;
  logic [PEN_W-1:0]      held_pen_q;
  logic [COL_W-1:0]      held_col_q;
  logic                  held_q;
  logic [TBL_DATA_W-1:0] color_lut [TBL_DEPTH];
  logic                  bank_q;

  // Pixels that the mixer still owes us, oldest first.
  plm_result_t pending_pixels [$];
  plm_result_t checked_pixel;

  int errors = 0;
  int pixel_reqs = 0;
  int table_reqs = 0;
  int pixels_seen = 0;
  int flushes = 0;
  int cycle_count = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t ns: timeout, %0d pixels still expected", $time, pending_pixels.size());
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Works out what one accepted request does to the state and which pixels it releases.
  task automatic predict_request(input mix_req_t r);
    logic [NIB_W-1:0] d1;
    logic [NIB_W-1:0] d2;
    logic [NIB_W-1:0] sp;
    logic [7:0]       pal;
    logic [PEN_W-1:0] pen;
    logic             front;
    plm_result_t      outs [2];
    int               n;
    n = 0;
    front = 1'b0;
    pal = r.bg;
    if (r.action == ACT_TABLE) begin
      color_lut[r.tidx] = r.tdata;
      table_reqs++;
      return;
    end
    pixel_reqs++;
    // A new line restarts the sprite delay and counts as if a front pixel came before it,
    // so the first pixel of a line never shadows anything.
    if (r.column == '0) begin
      tap_one = '0;
      tap_two = '0;
      last_front = 1'b1;
    end
    d1 = tap_one;
    d2 = tap_two;
    tap_two = tap_one;
    tap_one = r.nibble;
    if (r.text_on) begin
      pen = PEN_W'({bank_q, r.text_color});
      front = 1'b1;
    end else begin
      // A lone transparent nibble between two opaque ones is filled from the older tap.
      if (r.nibble != NIB_CLEAR && d1 == NIB_CLEAR && d2 != NIB_CLEAR)
        sp = d2;
      else
        sp = d1;
      if (sp != NIB_CLEAR && r.column >= SPRITE_MIN_COL) begin
        pal = color_lut[{bank_q, sp}];
        front = 1'b1;
      end
      pen = PEN_W'(PEN_ORIGIN + 64 * int'(pal) + int'(r.shade));
    end
    if (front && !last_front && r.column != '0)
      held_pen_q = '0;
    last_front = front;
    if (held_q) begin
      outs[n] = '{pen: held_pen_q, column: held_col_q, last: 1'b0};
      n++;
    end
    if (r.column >= LAST_COL) begin
      outs[n] = '{pen: pen, column: r.column, last: 1'b0};
      n++;
      held_q = 1'b0;
      held_pen_q = '0;
      held_col_q = '0;
      flushes++;
    end else begin
      held_pen_q = pen;
      held_col_q = r.column;
      held_q = 1'b1;
    end
    if (n > 0)
      outs[n-1].last = 1'b1;
    for (int k = 0; k < n; k++)
      pending_pixels.push_back(outs[k]);
  endtask

  // Every accepted pixel is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: unexpected pixel, expected none, got pen %0d column %0d last %0d",
                   $time, out_pen, out_pixel_column, out_last);
      end else begin
        checked_pixel = pending_pixels.pop_front();
        if (out_pen !== checked_pixel.pen)
          report_mismatch("pen", checked_pixel.pen, out_pen);
        if (out_pixel_column !== checked_pixel.column)
          report_mismatch("pixel_column", checked_pixel.column, out_pixel_column);
        if (out_last !== checked_pixel.last)
          report_mismatch("last", checked_pixel.last, out_last);
      end
    end
  end

  // The consumer draws a stall before each pixel, or none at all while rx_idle is clear.
  // out_ready is only lowered when a stall is drawn, so back-to-back pixels see it stay high.
  initial begin : pixel_sink
    int stall;
    forever begin
      stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Sends one request and updates the prediction once the mixer has taken it. It is always
  // entered right after a rising edge. With no gap drawn, in_valid stays high and only the
  // payload moves on to the next request.
  task automatic send_request(input mix_req_t r);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action <= r.action;
    in_column <= r.column;
    in_text_on <= r.text_on;
    in_text_color <= r.text_color;
    in_sprite_nibble <= r.nibble;
    in_bg_index <= r.bg;
    in_shade <= r.shade;
    in_table_index <= r.tidx;
    in_table_data <= r.tdata;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(r);
  endtask

  // Holds off the sender until every pending pixel has come out, then lets the mixer settle.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic mix_req_t pixel_at(input logic [COL_W-1:0] col, input logic txt,
                                        input logic [3:0] tcol, input logic [3:0] nib,
                                        input logic [7:0] bg, input logic [5:0] shd);
    mix_req_t r;
    r.action = ACT_PIXEL;
    r.column = col;
    r.text_on = txt;
    r.text_color = tcol;
    r.nibble = nib;
    r.bg = bg;
    r.shade = shd;
    r.tidx = TBL_IDX_W'($urandom);
    r.tdata = TBL_DATA_W'($urandom);
    return r;
  endfunction

  // Text on about one pixel in five and a transparent sprite nibble on about half, so that
  // every gap-fill pattern and every front/background transition shows up often.
  function automatic mix_req_t random_pixel(input logic [COL_W-1:0] col);
    logic [3:0] nib;
    nib = $urandom_range(0, 1) ? NIB_CLEAR : 4'($urandom_range(0, 15));
    return pixel_at(col, $urandom_range(0, 4) == 0, 4'($urandom), nib, 8'($urandom),
                    6'($urandom));
  endfunction

  function automatic mix_req_t table_req(input logic [TBL_IDX_W-1:0] idx,
                                         input logic [TBL_DATA_W-1:0] data);
    mix_req_t r;
    r = random_pixel(COL_W'($urandom));
    r.action = ACT_TABLE;
    r.tidx = idx;
    r.tdata = data;
    return r;
  endfunction

  // Reads the color bank register and compares it with the bench's copy.
  task automatic check_color_bank();
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= BANK_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'b0, bank_q})
      report_mismatch("color bank readback", {31'b0, bank_q}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the color bank register, upper bits included, and reads it back.
  task automatic set_color_bank(input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= BANK_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    bank_q = value[0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    check_color_bank();
  endtask

  // Reset value, both values of the bank bit, with the unused upper bits set and clear.
  task automatic test_register_access();
    check_color_bank();
    set_color_bank(32'hffff_ffff);
    set_color_bank(32'hffff_fffe);
    set_color_bank(32'h0000_0001);
    set_color_bank(32'h0000_0000);
  endtask

  // The table has no reset, so every entry is written before any sprite is shown.
  task automatic test_load_color_table();
    for (int i = 0; i < TBL_DEPTH; i++)
      send_request(table_req(TBL_IDX_W'(i), TBL_DATA_W'($urandom)));
  endtask

  // Hand-made lines, color bank 0, covering each corner of the mixing rules.
  task automatic test_directed_line_cases();
    mix_req_t r;
    // Extreme table values on the entries used below. A table write whose pixel fields sit at
    // their extremes must still be nothing more than a write.
    send_request(table_req(5'd2, 8'hff));
    send_request(table_req(5'd9, 8'h00));
    r = pixel_at(LAST_COL, 1'b1, 4'hf, 4'h0, 8'hff, 6'h3f);
    r.action = ACT_TABLE;
    r.tidx = 5'd31;
    r.tdata = 8'hff;
    send_request(r);
    // Text at column 0 is front but shadows nothing, and nothing is held before it.
    send_request(pixel_at(8'd0, 1'b1, 4'hf, NIB_CLEAR, 8'h00, 6'h00));
    // Largest and smallest background pens.
    send_request(pixel_at(8'd1, 1'b0, 4'h0, NIB_CLEAR, 8'hff, 6'h3f));
    send_request(pixel_at(8'd2, 1'b0, 4'h0, 4'h2, 8'h00, 6'h00));
    // The sprite reaches the tap at column 3, below the first sprite column: still background.
    send_request(pixel_at(8'd3, 1'b0, 4'h0, NIB_CLEAR, 8'h10, 6'h01));
    // A one-pixel gap is filled from the older tap, and this first front pixel shadows column 3.
    send_request(pixel_at(8'd4, 1'b0, 4'h0, 4'h9, 8'h20, 6'h02));
    send_request(pixel_at(8'd5, 1'b0, 4'h0, NIB_CLEAR, 8'h30, 6'h03));
    // Two transparent nibbles in a row: the gap is not filled and background shows.
    send_request(pixel_at(8'd6, 1'b0, 4'h0, NIB_CLEAR, 8'h40, 6'h04));
    // Text right after background shadows the background pixel.
    send_request(pixel_at(8'd7, 1'b1, 4'h5, 4'h0, 8'h50, 6'h05));
    // Columns that skip ahead: the sprite tap of column 7 carries over, so no pixel is shadowed.
    send_request(pixel_at(8'd200, 1'b0, 4'h0, NIB_CLEAR, 8'h60, 6'h06));
    send_request(pixel_at(8'd250, 1'b1, 4'ha, NIB_CLEAR, 8'h70, 6'h07));
    // The last column flushes both the held pixel and the new one.
    send_request(pixel_at(LAST_COL, 1'b0, 4'h0, NIB_CLEAR, 8'h80, 6'h08));
    // A line that never reaches its end: the pixel held at the next column 0 comes out as is.
    send_request(pixel_at(8'd0, 1'b0, 4'h0, 4'h4, 8'h90, 6'h09));
    send_request(pixel_at(8'd1, 1'b0, 4'h0, 4'h4, 8'ha0, 6'h0a));
    send_request(pixel_at(8'd2, 1'b0, 4'h0, 4'h4, 8'hb0, 6'h0b));
    send_request(pixel_at(8'd0, 1'b1, 4'h3, 4'h4, 8'hc0, 6'h0c));
    send_request(pixel_at(8'd254, 1'b0, 4'h0, 4'h0, 8'hd0, 6'h0d));
    // Flush with a text pixel after a sprite pixel: no shadow between front pixels.
    send_request(pixel_at(LAST_COL, 1'b1, 4'hc, 4'h0, 8'he0, 6'h0e));
  endtask

  // One pixel of a random line, now and then preceded by a table rewrite.
  task automatic send_scan_pixel(input int col);
    if ($urandom_range(0, 39) == 0)
      send_request(table_req(TBL_IDX_W'($urandom), TBL_DATA_W'($urandom)));
    send_request(random_pixel(COL_W'(col)));
  endtask

  // Random lines until about `target` pixel requests have gone out. Half of the lines are well
  // formed: they start at column 0, run a while, skip ahead and end with a flush. The rest are
  // full lines, lines given up midway, lines that start without column 0 and scattered columns.
  task automatic test_random_lines(input int target, input bit tx_mode, input bit rx_mode);
    int start_count;
    int kind;
    int a;
    int b;
    int n;
    tx_idle = tx_mode;
    rx_idle = rx_mode;
    start_count = pixel_reqs;
    while (pixel_reqs - start_count < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 10) begin
        a = $urandom_range(0, 30);
        b = $urandom_range(200, 255);
        for (int c = 0; c <= a; c++) send_scan_pixel(c);
        for (int c = b; c <= 255; c++) send_scan_pixel(c);
      end else if (kind == 10) begin
        for (int c = 0; c <= 255; c++) send_scan_pixel(c);
      end else if (kind < 15) begin
        a = $urandom_range(0, 40);
        for (int c = 0; c <= a; c++) send_scan_pixel(c);
      end else if (kind < 18) begin
        a = $urandom_range(1, 250);
        n = $urandom_range(1, 8);
        for (int c = a; c < a + n && c <= 255; c++) send_scan_pixel(c);
      end else begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0)
            send_scan_pixel($urandom_range(0, 1) ? 255 : 0);
          else
            send_scan_pixel($urandom_range(0, 255));
        end
      end
    end
  endtask

  initial begin : main_sequence
    tap_one = '0;
    tap_two = '0;
    last_front = 1'b1;
    held_pen_q = '0;
    held_col_q = '0;
    held_q = 1'b0;
    bank_q = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_load_color_table();
    test_directed_line_cases();

    // Each phase starts from an idle mixer with a new bank setting and a new traffic mix.
    hold_until_drained();
    set_color_bank(32'h0000_0001);
    test_random_lines(340, 1'b1, 1'b1);

    hold_until_drained();
    set_color_bank({$urandom} & 32'hffff_fffe);
    test_random_lines(340, 1'b0, 1'b0);

    hold_until_drained();
    set_color_bank({$urandom} | 32'h0000_0001);
    test_random_lines(340, 1'b1, 1'b0);

    hold_until_drained();
    set_color_bank($urandom);
    test_random_lines(320, 1'b0, 1'b1);

    hold_until_drained();
    $display("Summary: %0d pixel requests and %0d table writes sent, %0d pixels checked, %0d flushes.",
             pixel_reqs, table_reqs, pixels_seen, flushes);
    $display("Both color banks were used, with full-rate and stalled traffic on each side.");
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/plm_pkg.sv
hw/rtl/plm_outq.sv
hw/rtl/pixel_layer_mixer_with_drop_shadow.sv
tb/testbench.sv
